>>> sv/gws_pkg.sv
package gws_pkg;

    localparam int ADDR_W = 4;

    // register indexes (byte address = 4 * index)
    localparam logic [1:0] REG_FREQ  = 2'd0;
    localparam logic [1:0] REG_SHIFT = 2'd1;
    localparam logic [1:0] REG_SCALE = 2'd2;
    localparam logic [1:0] REG_MODE  = 2'd3;

    localparam logic [31:0] RST_FREQ  = 32'h0100_0000;
    localparam logic [31:0] RST_SHIFT = 32'h0000_0000;
    localparam logic [31:0] RST_SCALE = 32'h0001_0000;

    // pi^2 in Q4.28, ln 2 in Q.32, one in Q.32
    localparam logic [31:0] PI2_Q28 = 32'd2649351758;
    localparam logic [31:0] LN2_Q32 = 32'd2977044472;
    localparam logic [32:0] ONE_Q32 = 33'h1_0000_0000;

    // sideband from the argument stages through the exponential
    typedef struct packed {
        logic        zero;
        logic        sneg;
        logic [31:0] as;
        logic [6:0]  n;
        logic [37:0] u;
    } t_side0;

    // sideband through the divider
    typedef struct packed {
        logic              zero;
        logic              fz;
        logic              neg;
        logic              rick;
        logic [63:0]       rp;
        logic signed [8:0] e;
    } t_side1;

    function automatic logic [6:0] lzc64(input logic [63:0] v);
        logic [6:0] c;
        logic       found;
        c     = 7'd64;
        found = 1'b0;
        for (int i = 63; i >= 0; i--) begin
            if (!found && v[i]) begin
                c     = 7'(63 - i);
                found = 1'b1;
            end
        end
        return c;
    endfunction

    // fix up a reciprocal quotient estimate and form the next Horner term
    function automatic logic [32:0] horner_next(input logic [31:0] v,
                                                input logic [31:0] q0,
                                                input logic [3:0]  k);
        logic [35:0] prodk;
        logic [31:0] rem;
        logic [31:0] q;
        prodk = q0 * k;
        rem   = v - prodk[31:0];
        q     = (rem >= 32'(k)) ? q0 + 32'd1 : q0;
        return ONE_Q32 - {1'b0, q};
    endfunction

endpackage

>>> sv/gws_front.sv
module gws_front (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_en,
    input  logic           i_valid,
    input  logic [31:0]    i_time,
    input  logic [31:0]    i_shift,
    input  logic [31:0]    i_freq,
    input  logic [31:0]    i_scale,
    output logic           o_valid,
    output logic [31:0]    o_rem,
    output gws_pkg::t_side0 o_side
);
    import gws_pkg::*;

    logic [5:0]  r_v;
    logic [31:0] r_as [6];
    logic        r_sn [6];

    logic [32:0] n_x, n_ax;
    logic [31:0] n_as;
    logic [32:0] r0_ax;

    logic [64:0] n_w;
    logic        r1_tail;
    logic [31:0] r1_wq;

    logic [63:0] n_w2p;
    logic        r2_tail;
    logic [31:0] r2_w2;

    logic [63:0] n_up;
    logic        r3_tail;
    logic [37:0] r3_u;

    logic [37:0] n_rem4;
    logic [3:0]  n_nhi;
    logic [37:0] r4_rem;
    logic [3:0]  r4_nhi;
    logic        r4_tail;
    logic [37:0] r4_u;

    logic [37:0] n_rem5;
    logic [2:0]  n_nlo;
    logic [31:0] r5_r;
    logic [6:0]  r5_n;
    logic        r5_tail;
    logic [37:0] r5_u;

    always_comb begin
        n_x  = {i_time[31], i_time} - {i_shift[31], i_shift};
        n_ax = n_x[32] ? (~n_x + 33'd1) : n_x;
        n_as = i_scale[31] ? (~i_scale + 32'd1) : i_scale;
    end

    assign n_w   = i_freq * r0_ax;
    assign n_w2p = r1_wq * r1_wq;
    assign n_up  = r2_w2 * PI2_Q28;

    // n = u / ln2, four quotient bits here and three in the next stage
    always_comb begin
        logic [37:0] lim;
        n_rem4 = r3_u;
        n_nhi  = '0;
        for (int i = 3; i >= 0; i--) begin
            lim = 38'(LN2_Q32) << (i + 3);
            if (n_rem4 >= lim) begin
                n_rem4   = n_rem4 - lim;
                n_nhi[i] = 1'b1;
            end
        end
    end

    always_comb begin
        logic [37:0] lim;
        n_rem5 = r4_rem;
        n_nlo  = '0;
        for (int i = 2; i >= 0; i--) begin
            lim = 38'(LN2_Q32) << i;
            if (n_rem5 >= lim) begin
                n_rem5   = n_rem5 - lim;
                n_nlo[i] = 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v <= '0;
        end else if (i_en) begin
            r_v <= {r_v[4:0], i_valid};
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_as[0] <= n_as;
            r_sn[0] <= i_scale[31];
            for (int s = 1; s < 6; s++) begin
                r_as[s] <= r_as[s-1];
                r_sn[s] <= r_sn[s-1];
            end
            r0_ax   <= n_ax;
            r1_tail <= |n_w[64:46];
            r1_wq   <= n_w[45:14];
            r2_tail <= r1_tail;
            r2_w2   <= n_w2p[63:32];
            r3_tail <= r2_tail | (|n_up[63:62]);
            r3_u    <= n_up[61:24];
            r4_rem  <= n_rem4;
            r4_nhi  <= n_nhi;
            r4_tail <= r3_tail;
            r4_u    <= r3_u;
            r5_r    <= n_rem5[31:0];
            r5_n    <= {r4_nhi, n_nlo};
            r5_tail <= r4_tail;
            r5_u    <= r4_u;
        end
    end

    assign o_valid     = r_v[5];
    assign o_rem       = r5_r;
    assign o_side.zero = r5_tail | (r_as[5] == 32'd0);
    assign o_side.sneg = r_sn[5];
    assign o_side.as   = r_as[5];
    assign o_side.n    = r5_n;
    assign o_side.u    = r5_u;

endmodule

>>> sv/gws_exp.sv
module gws_exp (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_en,
    input  logic            i_valid,
    input  logic [31:0]     i_r,
    input  gws_pkg::t_side0 i_side,
    output logic            o_valid,
    output logic [32:0]     o_p,
    output gws_pkg::t_side0 o_side
);
    import gws_pkg::*;

    localparam int TERMS  = 12;
    localparam int STAGES = 2 * TERMS + 1;

    logic [STAGES-1:0] r_val;
    t_side0            r_side [STAGES];
    logic [31:0]       r_r    [2*TERMS-2];
    logic [31:0]       r_va   [TERMS];
    logic [31:0]       r_vb   [TERMS];
    logic [31:0]       r_qb   [TERMS];
    logic [32:0]       r_p;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_val <= '0;
        end else if (i_en) begin
            r_val <= {r_val[STAGES-2:0], i_valid};
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_side[0] <= i_side;
            r_r[0]    <= i_r;
            for (int s = 1; s < STAGES; s++) r_side[s] <= r_side[s-1];
            for (int s = 1; s < 2 * TERMS - 2; s++) r_r[s] <= r_r[s-1];
        end
    end

    // Horner over k = 12 down to 1: multiply by r, then divide by k through
    // a reciprocal; the one-step fixup runs ahead of the next multiply
    for (genvar j = 0; j < TERMS; j++) begin : g_term
        localparam logic [32:0] MK = 33'((64'd1 << 32) / (TERMS - j));
        logic [32:0] p_in;
        logic [31:0] r_in;
        logic [64:0] prod_a;
        logic [64:0] prod_b;

        if (j == 0) begin : g_first
            assign p_in = ONE_Q32;
            assign r_in = i_r;
        end else begin : g_next
            assign p_in = horner_next(r_vb[j-1], r_qb[j-1], 4'(TERMS + 1 - j));
            assign r_in = r_r[2*j-1];
        end

        assign prod_a = r_in * p_in;
        assign prod_b = r_va[j] * MK;

        always_ff @(posedge i_clk) begin
            if (i_en) begin
                r_va[j] <= prod_a[63:32];
                r_vb[j] <= r_va[j];
                r_qb[j] <= prod_b[63:32];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_p <= horner_next(r_vb[TERMS-1], r_qb[TERMS-1], 4'd1);
        end
    end

    assign o_valid = r_val[STAGES-1];
    assign o_p     = r_p;
    assign o_side  = r_side[STAGES-1];

endmodule

>>> sv/gws_div.sv
module gws_div (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_en,
    input  logic            i_valid,
    input  logic [63:0]     i_num,
    input  logic [31:0]     i_den,
    input  gws_pkg::t_side1 i_side,
    output logic            o_valid,
    output logic [35:0]     o_q,
    output gws_pkg::t_side1 o_side
);
    import gws_pkg::*;

    localparam int QW     = 36;
    localparam int STEPS  = 3;
    localparam int STAGES = QW / STEPS;

    logic [STAGES-1:0] r_v;
    logic [31:0]       r_rem [STAGES];
    logic [63:0]       r_num [STAGES];
    logic [QW-1:0]     r_q   [STAGES];
    t_side1            r_sd  [STAGES];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v <= '0;
        end else if (i_en) begin
            r_v <= {r_v[STAGES-2:0], i_valid};
        end
    end

    // restoring division, three quotient bits per stage
    for (genvar g = 0; g < STAGES; g++) begin : g_stage
        logic [31:0]   rem_in;
        logic [63:0]   num_in;
        logic [QW-1:0] q_in;
        t_side1        sd_in;
        logic [31:0]   rem_nx;
        logic [QW-1:0] q_nx;

        if (g == 0) begin : g_first
            assign rem_in = {4'd0, i_num[63:QW]};
            assign num_in = i_num;
            assign q_in   = '0;
            assign sd_in  = i_side;
        end else begin : g_next
            assign rem_in = r_rem[g-1];
            assign num_in = r_num[g-1];
            assign q_in   = r_q[g-1];
            assign sd_in  = r_sd[g-1];
        end

        always_comb begin
            logic [32:0] tmp;
            int          idx;
            rem_nx = rem_in;
            q_nx   = q_in;
            for (int m = 0; m < STEPS; m++) begin
                idx = QW - 1 - (g * STEPS + m);
                tmp = {rem_nx, num_in[idx]};
                if (tmp >= {1'b0, i_den}) begin
                    tmp       = tmp - {1'b0, i_den};
                    q_nx[idx] = 1'b1;
                end
                rem_nx = tmp[31:0];
            end
        end

        always_ff @(posedge i_clk) begin
            if (i_en) begin
                r_rem[g] <= rem_nx;
                r_num[g] <= num_in;
                r_q[g]   <= q_nx;
                r_sd[g]  <= sd_in;
            end
        end
    end

    assign o_valid = r_v[STAGES-1];
    assign o_q     = r_q[STAGES-1];
    assign o_side  = r_sd[STAGES-1];

endmodule

>>> sv/gws_back.sv
module gws_back (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_en,
    input  logic            i_valid,
    input  logic [32:0]     i_p,
    input  gws_pkg::t_side0 i_side,
    input  logic [31:0]     i_freq,
    input  logic            i_mode,
    output logic            o_valid,
    output logic [31:0]     o_amp,
    output logic            o_clip
);
    import gws_pkg::*;

    // frequency-derived divisor, follows the register
    logic [6:0]  n_lzf;
    logic [63:0] n_hp, n_dp;
    logic [4:0]  r_s;
    logic [31:0] r_f0n, r_h, r_d;
    logic        r_fzero;

    logic [3:0]  r_v;
    logic        r5_v, r_ov;

    logic [64:0] n_mag;
    logic [38:0] n_twou, n_c;
    logic [63:0] r1_mag;
    logic [38:0] r1_c;
    logic        r1_cpos;
    t_side0      r1_side;

    logic [6:0]  n_t, n_lzc, n_bl;
    logic [63:0] r2_mag;
    logic [5:0]  r2_t;
    logic [2:0]  r2_kk;
    logic        r2_cz;
    logic [38:0] r2_c;
    logic        r2_cpos;
    t_side0      r2_side;

    t_side1      n_s3;
    logic [63:0] r3_magn;
    logic [31:0] r3_cs;
    t_side1      r3_s1;

    logic [63:0] n_rp;
    t_side1      n_s4;
    logic [63:0] r4_magn;
    t_side1      r4_s1;

    logic        d_valid;
    logic [35:0] d_q;
    t_side1      d_side;

    logic [63:0]       n_pp;
    logic signed [8:0] n_e;
    logic [95:0]       n_t96;
    logic [8:0]        n_d;
    logic [63:0]       n_rs;
    logic [63:0]       n_base;
    logic              n_rbit, n_ovf;
    logic [63:0]       r5_base;
    logic              r5_rbit, r5_ovf, r5_neg;

    logic [64:0] n_sum, n_lim;
    logic        n_sat;
    logic [31:0] n_mg;
    logic [31:0] r_amp;
    logic        r_clip;

    assign n_lzf = lzc64({i_freq, 32'hFFFF_FFFF});
    assign n_hp  = r_f0n * r_f0n;
    assign n_dp  = r_h * PI2_Q28;

    always_ff @(posedge i_clk) begin
        r_s     <= n_lzf[4:0];
        r_f0n   <= i_freq << n_lzf[4:0];
        r_h     <= n_hp[63:32];
        r_d     <= n_dp[63:32];
        r_fzero <= (i_freq == 32'd0);
    end

    // stage 1: scaled exponential, Ricker factor |1 - 2u|
    assign n_mag  = i_side.as * i_p;
    assign n_twou = {i_side.u, 1'b0};
    assign n_c    = (n_twou > 39'(ONE_Q32)) ? n_twou - 39'(ONE_Q32)
                                            : 39'(ONE_Q32) - n_twou;

    // stage 2: normalize counts
    assign n_t   = lzc64(r1_mag);
    assign n_lzc = lzc64({25'd0, r1_c});
    assign n_bl  = 7'd64 - n_lzc;

    // stage 3: exponents, sign, special cases
    always_comb begin
        n_s3      = '0;
        n_s3.rick = i_mode;
        n_s3.zero = r2_side.zero | (i_mode & r2_cz);
        n_s3.fz   = !i_mode & r_fzero;
        n_s3.neg  = i_mode ? ((!r2_side.sneg) == r2_cpos) : r2_side.sneg;
        if (i_mode) begin
            n_s3.e = 9'(r2_kk) - 9'(r2_t) - 9'(r2_side.n) - 9'sd32;
        end else begin
            n_s3.e = 9'({r_s, 1'b0}) - 9'(r2_side.n) - 9'(r2_t) - 9'sd21;
        end
    end

    // stage 4: Ricker product
    assign n_rp = r3_magn[63:32] * r3_cs;
    always_comb begin
        n_s4    = r3_s1;
        n_s4.rp = n_rp;
    end

    gws_div u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (i_en),
        .i_valid (r_v[3]),
        .i_num   (r4_magn),
        .i_den   (r_d),
        .i_side  (r4_s1),
        .o_valid (d_valid),
        .o_q     (d_q),
        .o_side  (d_side)
    );

    // stage 5: binary scaling with round half up
    always_comb begin
        if (d_side.zero) begin
            n_pp = '0;
            n_e  = '0;
        end else if (d_side.fz) begin
            n_pp = 64'd1;
            n_e  = 9'sd64;
        end else begin
            n_pp = d_side.rick ? d_side.rp : {28'd0, d_q};
            n_e  = d_side.e;
        end
        n_t96  = {32'd0, n_pp} << n_e[4:0];
        n_d    = 9'(-n_e);
        n_rs   = n_pp >> (6'(n_d[5:0] - 6'd1));
        n_base = '0;
        n_rbit = 1'b0;
        n_ovf  = 1'b0;
        if (!n_e[8]) begin
            n_base = n_t96[63:0];
            n_ovf  = (n_pp != 64'd0) && ((n_e[7:5] != 3'd0) || (n_t96[95:64] != 32'd0));
        end else if (n_d < 9'd64) begin
            n_base = n_pp >> n_d[5:0];
            n_rbit = n_rs[0];
        end
    end

    // stage 6: saturate and apply sign
    always_comb begin
        n_sum = {1'b0, r5_base} + 65'(r5_rbit);
        n_lim = r5_neg ? 65'h0_8000_0000 : 65'h0_7FFF_FFFF;
        n_sat = r5_ovf | (n_sum > n_lim);
        n_mg  = n_sat ? n_lim[31:0] : n_sum[31:0];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v  <= '0;
            r5_v <= 1'b0;
            r_ov <= 1'b0;
        end else if (i_en) begin
            r_v  <= {r_v[2:0], i_valid};
            r5_v <= d_valid;
            r_ov <= r5_v;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r1_mag  <= n_mag[63:0];
            r1_c    <= n_c;
            r1_cpos <= n_twou < 39'(ONE_Q32);
            r1_side <= i_side;

            r2_mag  <= r1_mag;
            r2_t    <= n_t[5:0];
            r2_kk   <= (n_bl > 7'd32) ? 3'(n_bl - 7'd32) : 3'd0;
            r2_cz   <= (r1_c == 39'd0);
            r2_c    <= r1_c;
            r2_cpos <= r1_cpos;
            r2_side <= r1_side;

            r3_magn <= r2_mag << r2_t;
            r3_cs   <= 32'(r2_c >> r2_kk);
            r3_s1   <= n_s3;

            r4_magn <= r3_magn;
            r4_s1   <= n_s4;

            r5_base <= n_base;
            r5_rbit <= n_rbit;
            r5_ovf  <= n_ovf;
            r5_neg  <= d_side.neg;

            r_amp   <= r5_neg ? (32'd0 - n_mg) : n_mg;
            r_clip  <= n_sat;
        end
    end

    assign o_valid = r_ov;
    assign o_amp   = r_amp;
    assign o_clip  = r_clip;

endmodule

>>> sv/gaussian_wavelet_source_core.sv
// Gaussian / Ricker wavelet source. Each request on the slave stream carries
// one sample time (signed Q12.20 s); the block returns one amplitude
// (signed Q16.16, saturated, with a clip flag in tuser) per request, in
// order. Gaussian mode gives scale*exp(-a*x*x)/(2a), Ricker mode gives
// -scale*(1-2*a*x*x)*exp(-a*x*x), with x = t - time_shift and a = (pi*f0)^2.
// The datapath is a fully pipelined chain of 49 register stages: a new
// request is taken every cycle while the master side does not stall. Most
// of the depth comes from the 12-term Horner evaluation of exp (two stages
// per term) and the 36-bit restoring divider (three quotient bits per
// stage) used by the Gaussian normalization. A stall on the master side
// freezes the whole pipeline.
// Registers on the APB port: 0x0 center_frequency (Q8.24 Hz), 0x4
// time_shift (Q12.20 s), 0x8 amplitude_scale (Q16.16), 0xC ricker_mode
// (bit 0). Write them only while no request is in flight.
module gaussian_wavelet_source_core (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    // slave stream
    input  logic                        i_s_axis_tvalid,
    output logic                        o_s_axis_tready,
    input  logic [31:0]                 i_s_axis_tdata,   // [31:0] sample_time
    // master stream
    output logic                        o_m_axis_tvalid,
    input  logic                        i_m_axis_tready,
    output logic [31:0]                 o_m_axis_tdata,   // [31:0] amplitude
    output logic                        o_m_axis_tuser,   // [0] clipped
    // configuration
    input  logic                        psel,
    input  logic                        penable,
    input  logic                        pwrite,
    input  logic [gws_pkg::ADDR_W-1:0]  paddr,
    input  logic [31:0]                 pwdata,
    output logic [31:0]                 prdata,
    output logic                        pready
);
    import gws_pkg::*;

    logic [31:0] r_freq;
    logic [31:0] r_shift;
    logic [31:0] r_scale;
    logic        r_mode;
    logic        cfg_wr;

    logic        pipe_en;

    logic        f_valid;
    logic [31:0] f_rem;
    t_side0      f_side;

    logic        e_valid;
    logic [32:0] e_p;
    t_side0      e_side;

    logic        b_valid;
    logic [31:0] b_amp;
    logic        b_clip;

    // configuration registers
    assign pready = 1'b1;
    assign cfg_wr = psel & penable & pwrite & pready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_freq  <= RST_FREQ;
            r_shift <= RST_SHIFT;
            r_scale <= RST_SCALE;
            r_mode  <= 1'b0;
        end else if (cfg_wr) begin
            unique case (paddr[3:2])
                REG_FREQ:  r_freq  <= pwdata;
                REG_SHIFT: r_shift <= pwdata;
                REG_SCALE: r_scale <= pwdata;
                REG_MODE:  r_mode  <= pwdata[0];
                default:   r_mode  <= r_mode;
            endcase
        end
    end

    always_comb begin
        unique case (paddr[3:2])
            REG_FREQ:  prdata = r_freq;
            REG_SHIFT: prdata = r_shift;
            REG_SCALE: prdata = r_scale;
            REG_MODE:  prdata = {31'd0, r_mode};
            default:   prdata = 32'd0;
        endcase
    end

    // advance every stage whenever the output register is free or drained
    assign pipe_en         = !b_valid | i_m_axis_tready;
    assign o_s_axis_tready = pipe_en;

    // x, a*x*x, and the split u = n*ln2 + r
    gws_front u_front (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (pipe_en),
        .i_valid (i_s_axis_tvalid),
        .i_time  (i_s_axis_tdata),
        .i_shift (r_shift),
        .i_freq  (r_freq),
        .i_scale (r_scale),
        .o_valid (f_valid),
        .o_rem   (f_rem),
        .o_side  (f_side)
    );

    // exp(-r) in Q.32
    gws_exp u_exp (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (pipe_en),
        .i_valid (f_valid),
        .i_r     (f_rem),
        .i_side  (f_side),
        .o_valid (e_valid),
        .o_p     (e_p),
        .o_side  (e_side)
    );

    // scaling, Gaussian divide or Ricker product, rounding and saturation
    gws_back u_back (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (pipe_en),
        .i_valid (e_valid),
        .i_p     (e_p),
        .i_side  (e_side),
        .i_freq  (r_freq),
        .i_mode  (r_mode),
        .o_valid (b_valid),
        .o_amp   (b_amp),
        .o_clip  (b_clip)
    );

    assign o_m_axis_tvalid = b_valid;
    assign o_m_axis_tdata  = b_amp;
    assign o_m_axis_tuser  = b_clip;

endmodule
